// ----- src/graph_depth_first_timestamps_macros.svh -----
// Assertion macros shared by the search block.
// No dependencies.
`ifndef GRAPH_DEPTH_FIRST_TIMESTAMPS_MACROS_SVH
`define GRAPH_DEPTH_FIRST_TIMESTAMPS_MACROS_SVH
// implication checked on every clock edge outside reset
`define GDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define GDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/gdf_pkg.sv -----
// Types and constants of the depth-first search block.
// No dependencies.
package gdf_pkg;
  localparam int unsigned ResultCap = 32;

  localparam logic [2:0] StatusOk    = 3'd0;
  localparam logic [2:0] StatusSelf  = 3'd1;
  localparam logic [2:0] StatusDup   = 3'd2;
  localparam logic [2:0] StatusRange = 3'd3;
  localparam logic [2:0] StatusFull  = 3'd4;

  localparam logic [1:0] ColorWhite = 2'd0;
  localparam logic [1:0] ColorGray  = 2'd1;
  localparam logic [1:0] ColorBlack = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [4:0] from_node;
    logic [4:0] to_node;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] node_index;
    logic [5:0] discovery_time;
    logic [5:0] finish_time;
    logic [4:0] parent_node;
    logic       has_parent;
    logic       last;
  } out_word_t;

  typedef enum logic [10:0] {
    StIdle    = 11'b00000000001,
    StAddRd   = 11'b00000000010,
    StAddScan = 11'b00000000100,
    StAddEnd  = 11'b00000001000,
    StRoot    = 11'b00000010000,
    StTop     = 11'b00000100000,
    StEdgeRd  = 11'b00001000000,
    StEdge    = 11'b00010000000,
    StEmitRd  = 11'b00100000000,
    StEmit    = 11'b01000000000,
    StClear   = 11'b10000000000
  } state_e;

  // controller commands to the datapath
  typedef struct packed {
    logic take_in;
    logic add_rd;
    logic add_scan;
    logic add_end;
    logic root_step;
    logic top_step;
    logic edge_rd;
    logic edge_step;
    logic emit_rd;
    logic emit_step;
    logic clear_step;
  } cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic in_mode;
    logic add_early;
    logic scan_done;
    logic root_found;
    logic roots_done;
    logic top_has_edge;
    logic stack_empty;
    logic emit_last;
    logic out_free;
    logic clear_done;
  } stat_t;
endpackage

// ----- src/gdf_if.sv -----
// Valid/ready channel carrying one word.
// Depends on nothing but its type parameter.
interface gdf_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/gdf_ram.sv -----
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module gdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/gdf_ctrl.sv -----
// Controller state machine of the search block.
// Depends on gdf_pkg.
module gdf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  gdf_pkg::stat_t stat_i,
  output gdf_pkg::cmd_t  cmd_o
);
  gdf_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      gdf_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = stat_i.in_mode ? gdf_pkg::StRoot : gdf_pkg::StAddRd;
        end
      end
      gdf_pkg::StAddRd: begin
        if (stat_i.add_early) state_d = gdf_pkg::StAddEnd;
        else begin
          cmd_o.add_rd = 1'b1;
          state_d = gdf_pkg::StAddScan;
        end
      end
      gdf_pkg::StAddScan: begin
        cmd_o.add_scan = 1'b1;
        if (stat_i.scan_done) state_d = gdf_pkg::StAddEnd;
      end
      gdf_pkg::StAddEnd: begin
        if (stat_i.out_free) begin
          cmd_o.add_end = 1'b1;
          state_d = gdf_pkg::StIdle;
        end
      end
      gdf_pkg::StRoot: begin
        cmd_o.root_step = 1'b1;
        if (stat_i.roots_done) state_d = gdf_pkg::StEmitRd;
        else if (stat_i.root_found) state_d = gdf_pkg::StTop;
      end
      gdf_pkg::StTop: begin
        cmd_o.top_step = 1'b1;
        if (stat_i.top_has_edge) state_d = gdf_pkg::StEdgeRd;
        else if (stat_i.stack_empty) state_d = gdf_pkg::StRoot;
      end
      gdf_pkg::StEdgeRd: begin
        cmd_o.edge_rd = 1'b1;
        state_d = gdf_pkg::StEdge;
      end
      gdf_pkg::StEdge: begin
        cmd_o.edge_step = 1'b1;
        state_d = gdf_pkg::StTop;
      end
      gdf_pkg::StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d = gdf_pkg::StEmit;
      end
      gdf_pkg::StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          state_d = stat_i.emit_last ? gdf_pkg::StClear : gdf_pkg::StEmitRd;
        end
      end
      gdf_pkg::StClear: begin
        cmd_o.clear_step = 1'b1;
        state_d = gdf_pkg::StIdle;
      end
      default: state_d = gdf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gdf_pkg::StIdle;
    else state_q <= state_d;
  end
endmodule

// ----- src/gdf_dpath.sv -----
// Datapath: graph store, colours, stamps, walk stack and output register.
// Depends on gdf_pkg, gdf_ram and the assertion macros.
`include "graph_depth_first_timestamps_macros.svh"
module gdf_dpath #(
  parameter int unsigned MaxNodes = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        cfg_q_i,
  input  gdf_pkg::in_word_t in_i,
  input  gdf_pkg::cmd_t     cmd_i,
  output gdf_pkg::stat_t    stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output gdf_pkg::out_word_t out_o
);
  localparam int unsigned Cap  = (MaxNodes < 32) ? MaxNodes : 32;
  localparam int unsigned NW   = $clog2(Cap);
  localparam int unsigned CW   = $clog2(Cap + 1);
  localparam int unsigned Lcap = MaxNodes - 1;
  localparam int unsigned AW   = $clog2(Cap * Lcap);

  logic [CW-1:0] count;
  always_comb begin
    if (cfg_q_i == '0) count = CW'(1);
    else if ({26'd0, cfg_q_i} > 32'(Cap)) count = CW'(Cap);
    else count = CW'(cfg_q_i);
  end

  logic [4:0]     from_q, to_q;
  logic [2:0]     status_q;
  logic [CW-1:0]  len_q [Cap];
  logic [1:0]     color_q [Cap];
  logic [NW-1:0]  snode_q [Cap];
  logic [CW-1:0]  spos_q [Cap];
  logic [CW-1:0]  sp_q;
  logic [6:0]     clk_stamp_q;
  logic [CW-1:0]  root_q, scan_q, emit_q;
  logic           out_valid_q;
  gdf_pkg::out_word_t out_q;

  logic [NW-1:0] from_n, to_n, top_u;
  logic [CW-1:0] top_k, from_len;
  assign from_n = from_q[NW-1:0];
  assign to_n   = to_q[NW-1:0];
  assign top_u  = snode_q[sp_q[NW-1:0] - NW'(1)];
  assign top_k  = spos_q[sp_q[NW-1:0] - NW'(1)];
  assign from_len = len_q[from_n];

  // adjacency memory, one row of Lcap slots per node
  logic          adj_we;
  logic [AW-1:0] adj_wa, adj_ra;
  logic [4:0]    adj_rd;
  gdf_ram #(.Width(5), .Depth(Cap * Lcap)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(to_q),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );
  assign adj_we = cmd_i.add_end && status_q == gdf_pkg::StatusOk &&
                  from_len < count - CW'(1);
  assign adj_wa = AW'(from_n * Lcap + from_len);
  // during the scan, fetch one slot ahead of the one being compared
  always_comb begin
    if (cmd_i.edge_rd) adj_ra = AW'(top_u * Lcap + top_k);
    else adj_ra = AW'(from_n * Lcap + (cmd_i.add_scan ? scan_q + CW'(1) : scan_q));
  end

  // stamp memories written by discovery/finish, read for emission
  logic          disc_we, fin_we, par_we;
  logic [NW-1:0] disc_wa, fin_wa;
  logic [5:0]    disc_rd, fin_rd;
  logic [5:0]    par_rd;
  logic [CW-1:0] v_ext;
  logic          v_take;
  assign v_ext  = CW'(adj_rd);
  assign v_take = cmd_i.edge_step && v_ext < count &&
                  color_q[adj_rd[NW-1:0]] == gdf_pkg::ColorWhite && sp_q < CW'(Cap);
  assign disc_we = (cmd_i.root_step && !stat_o.roots_done && stat_o.root_found) || v_take;
  assign disc_wa = v_take ? adj_rd[NW-1:0] : root_q[NW-1:0];
  assign par_we  = disc_we;
  assign fin_we  = cmd_i.top_step && !stat_o.top_has_edge;
  assign fin_wa  = top_u;

  gdf_ram #(.Width(6), .Depth(Cap)) u_disc (
    .clk_i, .we_i(disc_we), .waddr_i(disc_wa), .wdata_i(clk_stamp_q[5:0]),
    .raddr_i(emit_q[NW-1:0]), .rdata_o(disc_rd)
  );
  gdf_ram #(.Width(6), .Depth(Cap)) u_fin (
    .clk_i, .we_i(fin_we), .waddr_i(fin_wa), .wdata_i(clk_stamp_q[5:0]),
    .raddr_i(emit_q[NW-1:0]), .rdata_o(fin_rd)
  );
  gdf_ram #(.Width(6), .Depth(Cap)) u_par (
    .clk_i, .we_i(par_we), .waddr_i(disc_wa),
    .wdata_i(v_take ? {1'b1, 5'(top_u)} : 6'd0),
    .raddr_i(emit_q[NW-1:0]), .rdata_o(par_rd)
  );

  // status towards the controller
  always_comb begin
    stat_o.in_mode      = in_i.mode;
    stat_o.add_early    = status_q != gdf_pkg::StatusOk || from_len == '0;
    stat_o.scan_done    = scan_q + CW'(1) >= from_len;
    stat_o.root_found   = color_q[root_q[NW-1:0]] == gdf_pkg::ColorWhite;
    stat_o.roots_done   = root_q >= count;
    stat_o.top_has_edge = top_k < len_q[top_u] && top_k < CW'(Lcap);
    stat_o.stack_empty  = sp_q == CW'(1);
    stat_o.emit_last    = emit_q + CW'(1) >= count;
    stat_o.out_free     = !out_valid_q || out_ready_i;
    stat_o.clear_done   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      clk_stamp_q <= '0;
      root_q      <= '0;
      scan_q      <= '0;
      emit_q      <= '0;
      status_q    <= gdf_pkg::StatusOk;
      for (int i = 0; i < Cap; i++) begin
        len_q[i]   <= '0;
        color_q[i] <= gdf_pkg::ColorWhite;
      end
    end else begin
      if (cmd_i.add_end || cmd_i.emit_step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.take_in) begin
        from_q <= in_i.from_node;
        to_q   <= in_i.to_node;
        root_q <= '0;
        emit_q <= '0;
        scan_q <= '0;
        if ({1'b0, in_i.from_node} >= 6'(count) || {1'b0, in_i.to_node} >= 6'(count))
          status_q <= gdf_pkg::StatusRange;
        else if (in_i.from_node == in_i.to_node) status_q <= gdf_pkg::StatusSelf;
        else status_q <= gdf_pkg::StatusOk;
      end
      if (cmd_i.add_scan) begin
        scan_q <= scan_q + CW'(1);
        if (adj_rd == to_q) status_q <= gdf_pkg::StatusDup;
      end
      if (cmd_i.add_end) begin
        out_q <= '{status: (status_q == gdf_pkg::StatusOk &&
                            from_len >= count - CW'(1)) ? gdf_pkg::StatusFull : status_q,
                   last: 1'b1, default: '0};
        if (status_q == gdf_pkg::StatusOk && from_len < count - CW'(1))
          len_q[from_n] <= from_len + CW'(1);
      end
      if (cmd_i.root_step && !stat_o.roots_done) begin
        if (stat_o.root_found) begin
          color_q[root_q[NW-1:0]] <= gdf_pkg::ColorGray;
          clk_stamp_q <= clk_stamp_q + 7'd1;
          snode_q[0] <= root_q[NW-1:0];
          spos_q[0]  <= '0;
          sp_q       <= CW'(1);
        end
        root_q <= root_q + CW'(1);
      end
      if (fin_we) begin
        color_q[top_u] <= gdf_pkg::ColorBlack;
        clk_stamp_q <= clk_stamp_q + 7'd1;
        sp_q <= sp_q - CW'(1);
      end
      if (cmd_i.edge_step) begin
        spos_q[sp_q[NW-1:0] - NW'(1)] <= top_k + CW'(1);
        if (v_take) begin
          color_q[adj_rd[NW-1:0]] <= gdf_pkg::ColorGray;
          clk_stamp_q <= clk_stamp_q + 7'd1;
          snode_q[sp_q[NW-1:0]] <= adj_rd[NW-1:0];
          spos_q[sp_q[NW-1:0]]  <= '0;
          sp_q <= sp_q + CW'(1);
        end
      end
      if (cmd_i.emit_step) begin
        out_q <= '{status: gdf_pkg::StatusOk, node_index: 5'(emit_q),
                   discovery_time: disc_rd, finish_time: fin_rd,
                   parent_node: par_rd[4:0], has_parent: par_rd[5],
                   last: stat_o.emit_last};
        emit_q <= emit_q + CW'(1);
      end
      if (cmd_i.clear_step) begin
        clk_stamp_q <= '0;
        for (int i = 0; i < Cap; i++) begin
          len_q[i]   <= '0;
          color_q[i] <= gdf_pkg::ColorWhite;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `GDF_ASSERT_IMPL(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= CW'(Cap))
  `GDF_ASSERT_IMPL(a_one_write, clk_i, rst_ni, 1'b1, !(fin_we && disc_we))
  `GDF_ASSERT_NEXT(a_clear_white, clk_i, rst_ni, cmd_i.clear_step,
                   color_q[0] == gdf_pkg::ColorWhite && clk_stamp_q == '0)
  `GDF_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_i.add_end || cmd_i.emit_step,
                   stat_o.out_free)
endmodule

// ----- src/graph_depth_first_timestamps.sv -----
// Top level of the depth-first search timestamp block.
// Depends on gdf_pkg, gdf_if, gdf_ctrl and gdf_dpath.
//
//  channel  direction  word
//  in_if    sink       mode, from_node, to_node
//  out_if   source     status, node_index, stamps, parent, last
//  cfg      write only node_count
//
// An edge add passes through the accept, read and end states; one that passes the
// range and self-loop checks also scans each target its source already holds (duplicate
// scan through the adjacency memory read port). A run tries each root in turn and then
// sees the roots done, visits the top, edge-read and edge states per stored edge examined,
// the top state per finish, then the emit-read and emit states per emitted node and a
// clear state; the single adjacency read port sets this. One result register holds a
// word; a stalled sink stops the controller. Reset is asynchronous and needs no clearing pass.
module graph_depth_first_timestamps #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  gdf_if.sink        in_if,
  gdf_if.source      out_if
);
  logic [5:0]     cfg_q;
  gdf_pkg::cmd_t  cmd;
  gdf_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= 6'd32;
    else if (cfg_we_i) cfg_q <= cfg_wdata_i;
  end

  assign in_if.ready = cmd.take_in;

  gdf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .stat_i(stat), .cmd_o(cmd)
  );

  gdf_dpath #(.MaxNodes(MAX_NODES)) u_dpath (
    .clk_i, .rst_ni, .cfg_q_i(cfg_q), .in_i(in_if.data), .cmd_i(cmd),
    .stat_o(stat), .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .out_o(out_if.data)
  );
endmodule

// ----- bench/gdf_tb_chan_if.sv -----
// Testbench-side helpers for the depth-first search block channels.
// Depends on gdf_pkg.
package gdf_tb_pkg;
  import gdf_pkg::*;

  localparam int unsigned MaxNodes = 32;
  localparam logic InModeAdd = 1'b0;
  localparam logic InModeRun = 1'b1;
endpackage

// ----- bench/gdf_checker.sv -----
// Watches the input and output channels and the register port of the search
// block, predicts every result word and compares it field by field.
// Depends on gdf_pkg and gdf_tb_pkg.
module gdf_checker
  import gdf_pkg::*;
  import gdf_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_word_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_word_t  out_data_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [5:0] count_reg;
  logic [4:0] adj [MaxNodes][MaxNodes];
  int         adj_len [MaxNodes];
  out_word_t  expected_words [$];

  function automatic int unsigned live_nodes();
    int unsigned c;
    c = count_reg;
    if (c < 1) c = 1;
    if (c > MaxNodes) c = MaxNodes;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  task automatic predict_add(input in_word_t w);
    int unsigned cnt;
    out_word_t r;
    cnt = live_nodes();
    r = '0;
    r.last = 1'b1;
    if (w.from_node >= cnt || w.to_node >= cnt) r.status = StatusRange;
    else if (w.from_node == w.to_node) r.status = StatusSelf;
    else begin
      for (int i = 0; i < adj_len[w.from_node]; i++)
        if (adj[w.from_node][i] == w.to_node) r.status = StatusDup;
      if (r.status == StatusOk && adj_len[w.from_node] >= cnt - 1) r.status = StatusFull;
      if (r.status == StatusOk) begin
        adj[w.from_node][adj_len[w.from_node]] = w.to_node;
        adj_len[w.from_node]++;
      end
    end
    expected_words = {expected_words, r};
  endtask

  task automatic predict_run();
    int unsigned cnt;
    int          clk_stamp;
    int          sp;
    int          stk_node [MaxNodes];
    int          stk_pos [MaxNodes];
    logic [1:0]  color [MaxNodes];
    out_word_t   res [MaxNodes];
    int          u;
    int          v;
    cnt = live_nodes();
    clk_stamp = 0;
    foreach (color[i]) color[i] = ColorWhite;
    foreach (res[i]) res[i] = '0;
    for (int root = 0; root < cnt; root++) begin
      if (color[root] == ColorWhite) begin
        sp = 0;
        color[root] = ColorGray;
        res[root].discovery_time = clk_stamp[5:0];
        clk_stamp = (clk_stamp + 1) & 'h7f;
        stk_node[0] = root;
        stk_pos[0] = 0;
        sp = 1;
        while (sp > 0) begin
          u = stk_node[sp-1];
          if (stk_pos[sp-1] < adj_len[u]) begin
            v = adj[u][stk_pos[sp-1]];
            stk_pos[sp-1]++;
            if (v < cnt && color[v] == ColorWhite) begin
              res[v].parent_node = u[4:0];
              res[v].has_parent = 1'b1;
              color[v] = ColorGray;
              res[v].discovery_time = clk_stamp[5:0];
              clk_stamp = (clk_stamp + 1) & 'h7f;
              stk_node[sp] = v;
              stk_pos[sp] = 0;
              sp++;
            end
          end else begin
            color[u] = ColorBlack;
            res[u].finish_time = clk_stamp[5:0];
            clk_stamp = (clk_stamp + 1) & 'h7f;
            sp--;
          end
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      res[i].node_index = i[4:0];
      res[i].last = (i + 1 == cnt);
      expected_words = {expected_words, res[i]};
    end
    foreach (adj_len[i]) adj_len[i] = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_reg = 6'd32;
      fail_count_o = 0;
      foreach (adj_len[i]) adj_len[i] = 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.mode == InModeRun) predict_run();
        else predict_add(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, node", out_data_i.node_index, 0);
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_data_i.status != e.status)
            report_mismatch("status", out_data_i.status, e.status);
          if (out_data_i.node_index != e.node_index)
            report_mismatch("node_index", out_data_i.node_index, e.node_index);
          if (out_data_i.discovery_time != e.discovery_time)
            report_mismatch("discovery_time", out_data_i.discovery_time, e.discovery_time);
          if (out_data_i.finish_time != e.finish_time)
            report_mismatch("finish_time", out_data_i.finish_time, e.finish_time);
          if (out_data_i.parent_node != e.parent_node)
            report_mismatch("parent_node", out_data_i.parent_node, e.parent_node);
          if (out_data_i.has_parent != e.has_parent)
            report_mismatch("has_parent", out_data_i.has_parent, e.has_parent);
          if (out_data_i.last != e.last)
            report_mismatch("last", out_data_i.last, e.last);
        end
      end
    end
    pending_o = expected_words.size();
  end
endmodule

// ----- bench/tb_graph_depth_first_timestamps.sv -----
// Stimulus and verdict for the depth-first search timestamp block.
// Depends on gdf_pkg, gdf_tb_pkg, gdf_if, gdf_checker and the RTL top.
module tb_graph_depth_first_timestamps;
  import gdf_pkg::*;
  import gdf_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = 6'd32;
  int         fail_count;
  int         words_pending;
  int         cycle_count = 0;
  bit         hold_sink = 1'b0;
  logic [5:0] cur_count = 6'd32;

  gdf_if #(.word_t(in_word_t))  in_if ();
  gdf_if #(.word_t(out_word_t)) out_if ();

  graph_depth_first_timestamps i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  gdf_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .fail_count_o(fail_count), .pending_o(words_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sink: random stalls per word, or a long hold when asked.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap != 0 || hold_sink) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_sink) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic send_word(input logic m, input logic [4:0] f, input logic [4:0] t, input bit gaps);
    in_word_t w;
    if (gaps) repeat ($urandom_range(0, 9)) @(posedge clk_i);
    w.mode = m;
    w.from_node = f;
    w.to_node = t;
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    in_if.valid <= 1'b0;
    // the block never takes a word on the cycle after an accept
    @(posedge clk_i);
  endtask

  task automatic drain_then_idle();
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [5:0] v);
    drain_then_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = (v == 0) ? 6'd1 : (v > 32 ? 6'd32 : v);
  endtask

  // One graph: random edges mostly within the count, then a run.
  task automatic random_graph(input int edges, input bit gaps);
    int n;
    n = cur_count;
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(InModeAdd, 5'($urandom), 5'($urandom), gaps);
      else
        send_word(InModeAdd, 5'($urandom_range(0, n - 1)), 5'($urandom_range(0, n - 1)), gaps);
    end
    send_word(InModeRun, 5'($urandom), 5'($urandom), gaps);
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: range, self loop, duplicate, full list, run at reset count
    send_word(InModeAdd, 5'd31, 5'd0, 0);
    send_word(InModeAdd, 5'd0, 5'd31, 0);
    send_word(InModeAdd, 5'd5, 5'd5, 0);
    send_word(InModeAdd, 5'd0, 5'd1, 0);
    send_word(InModeAdd, 5'd0, 5'd1, 0);
    send_word(InModeAdd, 5'd1, 5'd2, 0);
    send_word(InModeAdd, 5'd2, 5'd0, 0);
    send_word(InModeRun, 5'd0, 5'd0, 0);
    write_count(6'd3);
    send_word(InModeAdd, 5'd0, 5'd1, 0);
    send_word(InModeAdd, 5'd0, 5'd2, 0);
    send_word(InModeAdd, 5'd0, 5'd1, 0);
    send_word(InModeAdd, 5'd1, 5'd0, 0);
    send_word(InModeAdd, 5'd1, 5'd2, 0);
    send_word(InModeAdd, 5'd2, 5'd3, 0);
    write_count(6'd0);
    send_word(InModeAdd, 5'd0, 5'd0, 0);
    send_word(InModeRun, 5'd0, 5'd0, 0);
    // shrink after adding edges: stale targets must be skipped
    write_count(6'd8);
    send_word(InModeAdd, 5'd0, 5'd7, 0);
    send_word(InModeAdd, 5'd0, 5'd1, 0);
    send_word(InModeAdd, 5'd7, 5'd2, 0);
    write_count(6'd63);
    write_count(6'd4);
    send_word(InModeRun, 5'd0, 5'd0, 0);

    // hold the sink while the sender keeps offering
    write_count(6'd32);
    hold_sink = 1'b1;
    fork
      random_graph(12, 0);
      begin repeat (300) @(posedge clk_i); hold_sink = 1'b0; end
    join
    drain_then_idle();

    sent = 0;
    while (sent < 250) begin
      case ($urandom_range(0, 4))
        0: write_count(6'd2);
        1: write_count(6'd32);
        2: write_count(6'($urandom_range(0, 63)));
        default: write_count(6'($urandom_range(3, 10)));
      endcase
      for (int g = 0; g < 3 && sent < 250; g++) begin
        int e;
        e = $urandom_range(0, 4 * cur_count);
        if (e > 249 - sent) e = 249 - sent;
        random_graph(e, $urandom_range(0, 2) != 0);
        sent += e + 1;
      end
    end

    drain_then_idle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
